@@ src/owrs_pkg.sv @@
// Package with the item codes, status codes and limits of the 1-Wire ROM search engine.
`timescale 1ns / 1ps

package owrs_pkg;

  // Item function codes.
  localparam logic [1:0] FN_SETUP   = 2'd0;
  localparam logic [1:0] FN_FIRST   = 2'd1;
  localparam logic [1:0] FN_START   = 2'd2;
  localparam logic [1:0] FN_TRIPLET = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_ACK     = 2'd0;
  localparam logic [1:0] ST_TRIPLET = 2'd1;
  localparam logic [1:0] ST_FOUND   = 2'd2;
  localparam logic [1:0] ST_FAIL    = 2'd3;

  // Search geometry.
  localparam int unsigned ROM_BITS_TOTAL = 64;
  localparam int unsigned POS_W          = 7;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned FAM_DISC_W     = 4;

  localparam logic [POS_W-1:0] POS_FIRST    = 7'd1;
  localparam logic [POS_W-1:0] POS_LAST     = 7'd64;
  localparam logic [POS_W-1:0] POS_END      = 7'd65;
  localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;

  // Direction proposed for a bit position, given the current id and last discrepancy.
  function automatic logic choose_dir(input logic [POS_W-1:0] pos,
                                      input logic [POS_W-1:0] last_disc,
                                      input logic [ROM_BITS_TOTAL-1:0] rom);
    logic [IDX_W-1:0] idx;
    logic dir;
    idx = pos[IDX_W-1:0] - IDX_W'(1);
    if (pos < last_disc) begin
      dir = rom[idx];
    end else begin
      dir = (pos == last_disc);
    end
    return dir;
  endfunction

endpackage

@@ src/one_wire_rom_search.sv @@
// Top level of the 1-Wire search ROM engine: item register, search state and result register.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_stall    | func, family_code, presence, id_bit, complement_bit
// out_     | output    | out_valid / out_stall  | status, direction, bit_index, rom_id, last_device
//
// Every item gives exactly one result, offered on out_valid from the result register.
// One item can be accepted in every cycle without in_stall; the search state updates in one pass.
// rst_n is synchronous and active low; it clears the search state and both valid flags.
// A stalled result holds the result register; the item register then holds too and
// in_stall rises only when both stages are full.

module one_wire_rom_search
  import owrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_family_code,
  input  logic        in_presence,
  input  logic        in_id_bit,
  input  logic        in_complement_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_direction,
  output logic [6:0]  out_bit_index,
  output logic [63:0] out_rom_id,
  output logic        out_last_device
);

  // Item register.
  logic        in_vld_r;
  logic [1:0]  func_r;
  logic [7:0]  fam_r;
  logic        pres_r;
  logic        idb_r;
  logic        cmpb_r;

  // Search state.
  logic [ROM_BITS_TOTAL-1:0] rom_r, rom_nxt;
  logic [POS_W-1:0]          last_disc_r, last_disc_nxt;
  logic [FAM_DISC_W-1:0]     fam_disc_r, fam_disc_nxt;
  logic                      done_r, done_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [POS_W-1:0]          lzp_r, lzp_nxt;
  logic                      pdir_r, pdir_nxt;
  logic                      srch_r, srch_nxt;

  // Result register.
  logic                      out_vld_r;
  logic [1:0]                status_r, status_nxt;
  logic                      dir_r, dir_nxt;
  logic [POS_W-1:0]          bidx_r, bidx_nxt;
  logic [ROM_BITS_TOTAL-1:0] romid_r, romid_nxt;
  logic                      last_r, last_nxt;

  logic advance;
  logic take;

  // The item stage moves on when the result register is free or being emptied.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign take     = in_valid && !in_stall;

  // Item register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
    if (take) begin
      func_r <= in_func;
      fam_r  <= in_family_code;
      pres_r <= in_presence;
      idb_r  <= in_id_bit;
      cmpb_r <= in_complement_bit;
    end
  end

  // One search step for the item in the item register.
  always_comb begin
    logic             tdir;
    logic [IDX_W-1:0] widx;
    logic [POS_W-1:0] npos;
    rom_nxt       = rom_r;
    last_disc_nxt = last_disc_r;
    fam_disc_nxt  = fam_disc_r;
    done_nxt      = done_r;
    pos_nxt       = pos_r;
    lzp_nxt       = lzp_r;
    pdir_nxt      = pdir_r;
    srch_nxt      = srch_r;
    status_nxt    = ST_ACK;
    dir_nxt       = 1'b0;
    bidx_nxt      = '0;
    romid_nxt     = '0;
    last_nxt      = 1'b0;
    tdir          = pdir_r;
    widx          = pos_r[IDX_W-1:0] - IDX_W'(1);
    npos          = pos_r + POS_W'(1);

    unique case (func_r)
      FN_SETUP: begin
        rom_nxt       = {{(ROM_BITS_TOTAL-8){1'b0}}, fam_r};
        last_disc_nxt = POS_LAST;
        fam_disc_nxt  = '0;
        done_nxt      = 1'b0;
        srch_nxt      = 1'b0;
      end
      FN_FIRST: begin
        last_disc_nxt = '0;
        fam_disc_nxt  = '0;
        done_nxt      = 1'b0;
        srch_nxt      = 1'b0;
      end
      FN_START: begin
        if (done_r || !pres_r) begin
          last_disc_nxt = '0;
          fam_disc_nxt  = '0;
          done_nxt      = 1'b0;
          srch_nxt      = 1'b0;
          status_nxt    = ST_FAIL;
        end else begin
          pos_nxt    = POS_FIRST;
          lzp_nxt    = '0;
          pdir_nxt   = choose_dir(POS_FIRST, last_disc_r, rom_r);
          srch_nxt   = 1'b1;
          status_nxt = ST_TRIPLET;
          dir_nxt    = pdir_nxt;
          bidx_nxt   = POS_FIRST;
        end
      end
      FN_TRIPLET: begin
        if (!srch_r) begin
          status_nxt = ST_ACK;
        end else if (pos_r < POS_FIRST || pos_r > POS_LAST || (idb_r && cmpb_r)) begin
          // Out of range position or no device answering: the search fails.
          last_disc_nxt = '0;
          fam_disc_nxt  = '0;
          done_nxt      = 1'b0;
          srch_nxt      = 1'b0;
          status_nxt    = ST_FAIL;
        end else begin
          // A discrepancy where we took the zero branch.
          if (!idb_r && !cmpb_r && !pdir_r) begin
            lzp_nxt = pos_r;
            if (pos_r < FAMILY_LIMIT) begin
              fam_disc_nxt = pos_r[FAM_DISC_W-1:0];
            end
          end
          if (idb_r != cmpb_r) begin
            tdir = idb_r;
          end
          rom_nxt[widx] = tdir;
          pos_nxt       = npos;
          if (npos >= POS_END) begin
            srch_nxt      = 1'b0;
            last_disc_nxt = lzp_nxt;
            done_nxt      = done_r || (lzp_nxt == '0);
            if (rom_nxt[7:0] == 8'd0) begin
              last_disc_nxt = '0;
              fam_disc_nxt  = '0;
              done_nxt      = 1'b0;
              status_nxt    = ST_FAIL;
            end else begin
              status_nxt = ST_FOUND;
              romid_nxt  = rom_nxt;
              last_nxt   = done_nxt;
            end
          end else begin
            pdir_nxt   = choose_dir(npos, last_disc_r, rom_nxt);
            status_nxt = ST_TRIPLET;
            dir_nxt    = pdir_nxt;
            bidx_nxt   = npos;
          end
        end
      end
      default: begin
        status_nxt = ST_ACK;
      end
    endcase
  end

  // Search state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r       <= '0;
      last_disc_r <= '0;
      fam_disc_r  <= '0;
      done_r      <= 1'b0;
      pos_r       <= '0;
      lzp_r       <= '0;
      pdir_r      <= 1'b0;
      srch_r      <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (advance) begin
        rom_r       <= rom_nxt;
        last_disc_r <= last_disc_nxt;
        fam_disc_r  <= fam_disc_nxt;
        done_r      <= done_nxt;
        pos_r       <= pos_nxt;
        lzp_r       <= lzp_nxt;
        pdir_r      <= pdir_nxt;
        srch_r      <= srch_nxt;
        out_vld_r   <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r   <= 1'b0;
      end
    end
    if (advance) begin
      status_r <= status_nxt;
      dir_r    <= dir_nxt;
      bidx_r   <= bidx_nxt;
      romid_r  <= romid_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = status_r;
  assign out_direction   = dir_r;
  assign out_bit_index   = bidx_r;
  assign out_rom_id      = romid_r;
  assign out_last_device = last_r;

`ifndef SYNTHESIS
  // A triplet request always names a bit between 1 and 64.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r == ST_TRIPLET) |-> (bidx_r >= POS_FIRST && bidx_r <= POS_LAST))
    else $error("triplet result with bit index out of range");

  // While searching, the position stays inside the id.
  assert property (@(posedge clk) disable iff (!rst_n)
    srch_r |-> (pos_r >= POS_FIRST && pos_r <= POS_LAST))
    else $error("search position out of range");

  // The family discrepancy can only point into the first byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    fam_disc_r < FAMILY_LIMIT[FAM_DISC_W-1:0])
    else $error("family discrepancy beyond family byte");

  // Only a found device carries an id or the last device flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r != ST_FOUND) |-> (romid_r == '0 && !last_r))
    else $error("id or last device flag on a result that found nothing");

  // A search that ended and found the last device leaves no search running.
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !srch_r || $past(advance))
    else $error("search running after last device found");
`endif

endmodule
